// ===== rtl/qmsj_pkg.sv =====
// ----------------------------------------------------------------------------
// qmsj_pkg
// shared constants and control types for the quad minimum scaled jacobian
// ----------------------------------------------------------------------------
package qmsj_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 15;

    typedef struct packed {
        logic valid;
        logic deg;
    } ctl_t;

endpackage

// ===== rtl/qmsj_corner.sv =====
// ----------------------------------------------------------------------------
// qmsj_corner
// five stage front end for one corner: edge vectors, squared lengths,
// cross product, squared cross magnitude and length product
// ----------------------------------------------------------------------------
module qmsj_corner #(
    parameter int COORD_BITS = qmsj_pkg::COORD_BITS_DEF,
    localparam int DW   = COORD_BITS + 1,
    localparam int SQW  = 2 * DW - 1,
    localparam int L2W  = SQW + 2,
    localparam int PW   = 2 * DW,
    localparam int CRW  = PW + 1,
    localparam int CMW  = CRW - 1,
    localparam int C2W  = 2 * CMW + 2,
    localparam int DENW = 2 * L2W
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  qmsj_pkg::ctl_t                   ctl_in,
    input  logic [2:0][COORD_BITS-1:0]       p0,
    input  logic [2:0][COORD_BITS-1:0]       p1,
    input  logic [2:0][COORD_BITS-1:0]       p2,
    output qmsj_pkg::ctl_t                   ctl_out,
    output logic [C2W-1:0]                   c2,
    output logic [DENW-1:0]                  den
);

    qmsj_pkg::ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    qmsj_pkg::ctl_t ctl4_next;

    logic signed [DW-1:0]  u_reg [3];
    logic signed [DW-1:0]  v_reg [3];
    logic [SQW-1:0]        uu_reg [3];
    logic [SQW-1:0]        vv_reg [3];
    logic signed [PW-1:0]  xa_reg [3];
    logic signed [PW-1:0]  xb_reg [3];
    logic [L2W-1:0]        l2_reg, r2_reg;
    logic [CMW-1:0]        cm_reg [3];
    logic [2*CMW-1:0]      sq_reg [3];
    logic [DENW-1:0]       den4_reg, den5_reg;
    logic [C2W-1:0]        c2_reg;

    logic signed [DW-1:0]  u_next [3];
    logic signed [DW-1:0]  v_next [3];
    logic signed [PW-1:0]  uu_w [3];
    logic signed [PW-1:0]  vv_w [3];
    logic signed [PW-1:0]  xa_w [3];
    logic signed [PW-1:0]  xb_w [3];
    logic signed [CRW-1:0] cr_w [3];
    logic [CMW-1:0]        cm_next [3];
    logic [L2W-1:0]        l2_next, r2_next;
    logic [C2W-1:0]        c2_next;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        assign u_next[k] = $signed({p1[k][COORD_BITS-1], p1[k]})
                         - $signed({p0[k][COORD_BITS-1], p0[k]});
        assign v_next[k] = $signed({p2[k][COORD_BITS-1], p2[k]})
                         - $signed({p0[k][COORD_BITS-1], p0[k]});
        assign uu_w[k] = u_reg[k] * u_reg[k];
        assign vv_w[k] = v_reg[k] * v_reg[k];
        assign xa_w[k] = u_reg[(k + 1) % 3] * v_reg[(k + 2) % 3];
        assign xb_w[k] = u_reg[(k + 2) % 3] * v_reg[(k + 1) % 3];
        assign cr_w[k] = CRW'(xa_reg[k]) - CRW'(xb_reg[k]);
        always_comb begin
            if (cr_w[k][CRW-1]) begin
                cm_next[k] = CMW'(-cr_w[k]);
            end else begin
                cm_next[k] = CMW'(cr_w[k]);
            end
        end
    end

    assign l2_next = L2W'(uu_reg[0]) + L2W'(uu_reg[1]) + L2W'(uu_reg[2]);
    assign r2_next = L2W'(vv_reg[0]) + L2W'(vv_reg[1]) + L2W'(vv_reg[2]);
    assign c2_next = C2W'(sq_reg[0]) + C2W'(sq_reg[1]) + C2W'(sq_reg[2]);

    always_comb begin
        ctl4_next     = ctl3_reg;
        ctl4_next.deg = (l2_reg == '0) || (r2_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end else if (en) begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl4_next;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                u_reg[k]  <= u_next[k];
                v_reg[k]  <= v_next[k];
                uu_reg[k] <= uu_w[k][SQW-1:0];
                vv_reg[k] <= vv_w[k][SQW-1:0];
                xa_reg[k] <= xa_w[k];
                xb_reg[k] <= xb_w[k];
                cm_reg[k] <= cm_next[k];
                sq_reg[k] <= cm_reg[k] * cm_reg[k];
            end
            l2_reg   <= l2_next;
            r2_reg   <= r2_next;
            den4_reg <= l2_reg * r2_reg;
            den5_reg <= den4_reg;
            c2_reg   <= c2_next;
        end
    end

    assign ctl_out = ctl5_reg;
    assign c2      = c2_reg;
    assign den     = den5_reg;

endmodule

// ===== rtl/qmsj_div.sv =====
// ----------------------------------------------------------------------------
// qmsj_div
// pipelined restoring divider, one quotient bit per stage, gives
// floor(c2 * 2^(2*FRAC_BITS) / den) for c2 <= den
// ----------------------------------------------------------------------------
module qmsj_div #(
    parameter int COORD_BITS = qmsj_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = qmsj_pkg::FRAC_BITS_DEF,
    localparam int DENW = 4 * (COORD_BITS + 1) + 2,
    localparam int RW   = DENW + 1,
    localparam int QW   = 2 * FRAC_BITS + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  qmsj_pkg::ctl_t    ctl_in,
    input  logic [DENW-1:0]   c2,
    input  logic [DENW-1:0]   den,
    output qmsj_pkg::ctl_t    ctl_out,
    output logic [QW-1:0]     quo
);

    qmsj_pkg::ctl_t  ctl_reg [QW];
    logic [QW-1:0]   q_reg   [QW];
    logic [RW-1:0]   rem_reg [QW-1];
    logic [DENW-1:0] den_reg [QW-1];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [RW-1:0]   rin, rsub;
        logic [DENW-1:0] din;
        logic [QW-1:0]   qin, q_next;
        qmsj_pkg::ctl_t  cin;
        logic            ge;

        if (i == 0) begin : g_first
            assign rin = {1'b0, c2};
            assign din = den;
            assign qin = '0;
            assign cin = ctl_in;
        end else begin : g_rest
            assign rin = {rem_reg[i-1][RW-2:0], 1'b0};
            assign din = den_reg[i-1];
            assign qin = q_reg[i-1];
            assign cin = ctl_reg[i-1];
        end

        assign ge   = rin >= {1'b0, din};
        assign rsub = rin - {1'b0, din};

        always_comb begin
            q_next             = qin;
            q_next[QW - 1 - i] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[i] <= '0;
            end else if (en) begin
                ctl_reg[i] <= cin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i] <= q_next;
            end
        end

        if (i < QW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= ge ? rsub : rin;
                    den_reg[i] <= din;
                end
            end
        end
    end

    assign ctl_out = ctl_reg[QW-1];
    assign quo     = q_reg[QW-1];

endmodule

// ===== rtl/qmsj_sqrt.sv =====
// ----------------------------------------------------------------------------
// qmsj_sqrt
// pipelined digit by digit integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module qmsj_sqrt #(
    parameter int FRAC_BITS = qmsj_pkg::FRAC_BITS_DEF,
    localparam int SW = 2 * FRAC_BITS + 1,
    localparam int NS = FRAC_BITS + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  qmsj_pkg::ctl_t    ctl_in,
    input  logic [SW-1:0]     rad,
    output qmsj_pkg::ctl_t    ctl_out,
    output logic [NS-1:0]     root
);

    qmsj_pkg::ctl_t ctl_reg [NS];
    logic [SW-1:0]  res_reg [NS];
    logic [SW-1:0]  op_reg  [NS-1];

    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic [SW-1:0] ONE = SW'(1) << (2 * (FRAC_BITS - i));
        logic [SW-1:0]  oin, rin;
        logic [SW:0]    trial;
        qmsj_pkg::ctl_t cin;
        logic           ge;

        if (i == 0) begin : g_first
            assign oin = rad;
            assign rin = '0;
            assign cin = ctl_in;
        end else begin : g_rest
            assign oin = op_reg[i-1];
            assign rin = res_reg[i-1];
            assign cin = ctl_reg[i-1];
        end

        assign trial = {1'b0, rin} + {1'b0, ONE};
        assign ge    = {1'b0, oin} >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[i] <= '0;
            end else if (en) begin
                ctl_reg[i] <= cin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                res_reg[i] <= ge ? (rin >> 1) + ONE : rin >> 1;
            end
        end

        if (i < NS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    op_reg[i] <= ge ? oin - trial[SW-1:0] : oin;
                end
            end
        end
    end

    assign ctl_out = ctl_reg[NS-1];
    assign root    = res_reg[NS-1][NS-1:0];

endmodule

// ===== rtl/quad_min_scaled_jacobian_top.sv =====
// path: each corner's front end, divider and square root in that order, then the registered
// minimum over the four corners
// throughput: one request per cycle unless the output stalls, every stage takes a new request each enabled cycle
// all stages advance together; a stalled result holds the whole pipeline
// reset: synchronous active low aresetn clears the control words (valid and degenerate flags) and the output valid only
// ----------------------------------------------------------------------------
// quad_min_scaled_jacobian_top
// minimum scaled jacobian of a 3d quad over its four corner triangles
// ----------------------------------------------------------------------------
module quad_min_scaled_jacobian_top #(
    parameter int COORD_BITS = qmsj_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = qmsj_pkg::FRAC_BITS_DEF,
    localparam int DENW = 4 * (COORD_BITS + 1) + 2,
    localparam int QW   = 2 * FRAC_BITS + 1,
    localparam int OW   = FRAC_BITS + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_ax,
    input  logic [COORD_BITS-1:0] s_ay,
    input  logic [COORD_BITS-1:0] s_az,
    input  logic [COORD_BITS-1:0] s_bx,
    input  logic [COORD_BITS-1:0] s_by,
    input  logic [COORD_BITS-1:0] s_bz,
    input  logic [COORD_BITS-1:0] s_cx,
    input  logic [COORD_BITS-1:0] s_cy,
    input  logic [COORD_BITS-1:0] s_cz,
    input  logic [COORD_BITS-1:0] s_dx,
    input  logic [COORD_BITS-1:0] s_dy,
    input  logic [COORD_BITS-1:0] s_dz,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OW-1:0]         m_min_jacobian,
    output logic                  m_degenerate
);

    logic                          en;
    logic [3:0][2:0][COORD_BITS-1:0] pt;
    qmsj_pkg::ctl_t                ctl_in;
    qmsj_pkg::ctl_t                ctl_a [4];
    qmsj_pkg::ctl_t                ctl_b [4];
    qmsj_pkg::ctl_t                ctl_c [4];
    logic [DENW-1:0]               c2 [4];
    logic [DENW-1:0]               den [4];
    logic [QW-1:0]                 quo [4];
    logic [OW-1:0]                 root [4];

    logic                          m_valid_reg, m_valid_next;
    logic [OW-1:0]                 m_min_reg, m_min_next;
    logic                          m_deg_reg, m_deg_next;
    logic [OW-1:0]                 min01, min23;

    assign en     = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign pt[0] = {s_az, s_ay, s_ax};
    assign pt[1] = {s_bz, s_by, s_bx};
    assign pt[2] = {s_cz, s_cy, s_cx};
    assign pt[3] = {s_dz, s_dy, s_dx};

    always_comb begin
        ctl_in.valid = s_valid;
        ctl_in.deg   = 1'b0;
    end

    for (genvar j = 0; j < 4; j++) begin : g_corner
        qmsj_corner #(
            .COORD_BITS (COORD_BITS)
        ) u_corner (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl_in),
            .p0      (pt[j]),
            .p1      (pt[(j + 1) % 4]),
            .p2      (pt[(j + 3) % 4]),
            .ctl_out (ctl_a[j]),
            .c2      (c2[j]),
            .den     (den[j])
        );

        qmsj_div #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl_a[j]),
            .c2      (c2[j]),
            .den     (den[j]),
            .ctl_out (ctl_b[j]),
            .quo     (quo[j])
        );

        qmsj_sqrt #(
            .FRAC_BITS (FRAC_BITS)
        ) u_sqrt (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl_b[j]),
            .rad     (quo[j]),
            .ctl_out (ctl_c[j]),
            .root    (root[j])
        );
    end

    assign min01 = (root[1] < root[0]) ? root[1] : root[0];
    assign min23 = (root[3] < root[2]) ? root[3] : root[2];

    always_comb begin
        m_valid_next = ctl_c[0].valid;
        m_deg_next   = ctl_c[0].deg || ctl_c[1].deg || ctl_c[2].deg || ctl_c[3].deg;
        if (m_deg_next) begin
            m_min_next = '0;
        end else begin
            m_min_next = (min23 < min01) ? min23 : min01;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_min_reg <= m_min_next;
            m_deg_reg <= m_deg_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_min_jacobian = m_min_reg;
    assign m_degenerate   = m_deg_reg;

endmodule
